[src/cpu_tlq_pkg.sv]
// ----------------------------------------------------------------------------
// CPU time limit and quota throttle package
// Shared types, widths, register indexes and operation codes.
// ----------------------------------------------------------------------------
package cpu_tlq_pkg;

    // Time bases
    localparam int US_PER_TICK = 1000;
    localparam int US_PER_MS   = 1000;

    // Field and state widths
    localparam int LIMIT_W    = 40;
    localparam int USED_W     = 48;
    localparam int TICKS_W    = 64;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HARD_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_LIMIT_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_ENABLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_LIMIT_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTA_US      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US     = 3'd5;

    // Operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               hard_enable;
        logic [LIMIT_W-1:0] hard_limit_ms;
        logic               soft_enable;
        logic [LIMIT_W-1:0] soft_limit_ms;
        logic [LIMIT_W-1:0] quota_budget;
        logic [LIMIT_W-1:0] period_len;
    } cfg_t;

    typedef struct packed {
        logic               operation;
        logic [MS_W-1:0]    elapsed_ms;
        logic [TICKS_W-1:0] now_ticks;
    } in_item_t;

    typedef struct packed {
        logic hard_exceeded;
        logic soft_signal;
        logic quota_exceeded;
        logic can_schedule;
    } out_item_t;

endpackage

[src/cpu_tlq_if.sv]
// ----------------------------------------------------------------------------
// CPU time limit and quota throttle channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface cpu_tlq_req_if;
    import cpu_tlq_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface cpu_tlq_rsp_if;
    import cpu_tlq_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

[src/cpu_tlq_cfg.sv]
// ----------------------------------------------------------------------------
// CPU time limit and quota throttle configuration registers
// Write-only register file decoded from a plain index/data write port.
// ----------------------------------------------------------------------------
module cpu_tlq_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cpu_tlq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpu_tlq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output cpu_tlq_pkg::cfg_t                   cfg
);
    import cpu_tlq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; indexes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_HARD_ENABLE:   cfg_next.hard_enable   = cfg_wdata[0];
                REG_HARD_LIMIT_MS: cfg_next.hard_limit_ms = cfg_wdata[LIMIT_W-1:0];
                REG_SOFT_ENABLE:   cfg_next.soft_enable   = cfg_wdata[0];
                REG_SOFT_LIMIT_MS: cfg_next.soft_limit_ms = cfg_wdata[LIMIT_W-1:0];
                REG_QUOTA_US:      cfg_next.quota_budget  = cfg_wdata[LIMIT_W-1:0];
                REG_PERIOD_US:     cfg_next.period_len    = cfg_wdata[LIMIT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/cpu_tlq_acct.sv]
// ----------------------------------------------------------------------------
// CPU time limit and quota throttle accounting
// Holds the CPU-time and period state and works out one item's result.
// ----------------------------------------------------------------------------
module cpu_tlq_acct (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cpu_tlq_pkg::cfg_t      cfg,
    input  logic                   step,
    input  cpu_tlq_pkg::in_item_t  item,
    output cpu_tlq_pkg::out_item_t result
);
    import cpu_tlq_pkg::*;

    localparam int UPT_W     = $clog2(US_PER_TICK + 1);
    localparam int SINCE_W   = LIMIT_W + 1;
    localparam int SPAN_W    = SINCE_W + UPT_W;
    localparam int UPM_W     = $clog2(US_PER_MS + 1);
    localparam int MS_US_W   = MS_W + UPM_W;
    localparam int TOTAL_W   = LIMIT_W + 1;
    localparam int USED_SUM_W = USED_W + 1;

    logic [LIMIT_W-1:0] cpu_total_reg,   cpu_total_next;
    logic [USED_W-1:0]  period_used_reg, period_used_next;
    logic [TICKS_W-1:0] period_begin_reg, period_begin_next;
    logic               throttled_reg,   throttled_next;
    logic               soft_done_reg,   soft_done_next;

    logic [TOTAL_W-1:0]    total;
    logic                  hard_hit;
    logic                  soft_hit;
    logic [MS_US_W-1:0]    ms_us;
    logic [USED_SUM_W-1:0] used_sum;
    logic [USED_W-1:0]     used_sat;
    logic [USED_W-1:0]     used_eff;
    logic [TICKS_W-1:0]    since;
    logic [SINCE_W-1:0]    since_p1;
    logic [SPAN_W-1:0]     since_scaled;
    logic                  period_over;
    logic                  quota_on;
    logic                  quota_hit;
    logic                  is_tick;

    // Tick arithmetic: new total against the limits and usage in microseconds.
    assign is_tick  = (item.operation == OP_TICK);
    assign total    = TOTAL_W'(cpu_total_reg) + TOTAL_W'(item.elapsed_ms);
    assign hard_hit = cfg.hard_enable && (total > TOTAL_W'(cfg.hard_limit_ms));
    assign soft_hit = cfg.soft_enable && (total > TOTAL_W'(cfg.soft_limit_ms))
                      && !soft_done_reg;
    assign ms_us    = MS_US_W'(item.elapsed_ms) * MS_US_W'(US_PER_MS);
    assign used_sum = USED_SUM_W'(period_used_reg) + USED_SUM_W'(ms_us);
    assign used_sat = used_sum[USED_W] ? {USED_W{1'b1}} : used_sum[USED_W-1:0];
    assign quota_on = (cfg.quota_budget != '0);
    assign used_eff = (is_tick && quota_on) ? used_sat : period_used_reg;

    // Period check without a divider: since >= floor(P / U) holds exactly
    // when (since + 1) * U > P. A distance beyond the limit width always passes.
    assign since        = item.now_ticks - period_begin_reg;
    assign since_p1     = SINCE_W'(since[LIMIT_W-1:0]) + SINCE_W'(1);
    assign since_scaled = SPAN_W'(since_p1) * SPAN_W'(US_PER_TICK);
    assign period_over  = (since[TICKS_W-1:LIMIT_W] != '0)
                          || (since_scaled > SPAN_W'(cfg.period_len));
    assign quota_hit    = quota_on && !period_over
                          && (used_eff >= USED_W'(cfg.quota_budget));

    // Next state and result for the item in the input register.
    always_comb
    begin
        cpu_total_next    = cpu_total_reg;
        period_used_next  = period_used_reg;
        period_begin_next = period_begin_reg;
        throttled_next    = throttled_reg;
        soft_done_next    = soft_done_reg;
        result            = '0;

        if (is_tick && hard_hit)
        begin
            result.hard_exceeded = 1'b1;
        end
        else
        begin
            if (is_tick)
            begin
                result.soft_signal = soft_hit;
                if (soft_hit)
                begin
                    soft_done_next = 1'b1;
                end
                cpu_total_next = total[LIMIT_W] ? {LIMIT_W{1'b1}} : total[LIMIT_W-1:0];
                period_used_next = used_eff;
            end

            if (quota_on)
            begin
                if (period_over)
                begin
                    period_used_next  = '0;
                    period_begin_next = item.now_ticks;
                    throttled_next    = 1'b0;
                end
                else if (quota_hit)
                begin
                    throttled_next = 1'b1;
                end
            end
            result.quota_exceeded = quota_hit;

            if (!is_tick)
            begin
                result.can_schedule = !quota_hit
                    && !(cfg.hard_enable && (cpu_total_reg >= cfg.hard_limit_ms));
            end
        end
    end

    // State registers, updated only when an item moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_total_reg    <= '0;
            period_used_reg  <= '0;
            period_begin_reg <= '0;
            throttled_reg    <= 1'b0;
            soft_done_reg    <= 1'b0;
        end
        else if (step)
        begin
            cpu_total_reg    <= cpu_total_next;
            period_used_reg  <= period_used_next;
            period_begin_reg <= period_begin_next;
            throttled_reg    <= throttled_next;
            soft_done_reg    <= soft_done_next;
        end
    end

    // A terminated tick leaves the CPU total untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.hard_exceeded |=> $stable(cpu_total_reg))
        else $error("CPU total changed on a terminated tick");

    // The soft signal is raised once and then stays latched.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.soft_signal |-> !soft_done_reg ##1 soft_done_reg)
        else $error("soft signal raised more than once");

    // An exceeded quota leaves the process throttled.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.quota_exceeded |=> throttled_reg)
        else $error("throttle flag not set on exceeded quota");

    // With no quota, a query leaves the period untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !quota_on && (item.operation == OP_QUERY)
        |=> $stable(period_begin_reg) && $stable(period_used_reg))
        else $error("period state changed without a quota");

endmodule

[src/cpu_tlq_cfg_dummy_guard.sv]
// ----------------------------------------------------------------------------
// CPU time limit and quota throttle result stage
// Output register that holds a finished item until the sink takes it.
// ----------------------------------------------------------------------------
module cpu_tlq_cfg_dummy_guard (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  cpu_tlq_pkg::out_item_t result,
    output logic                   busy,
    cpu_tlq_rsp_if.source          rsp
);
    import cpu_tlq_pkg::*;

    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    out_item_t rsp_item_reg;

    // The register is free when empty or when its item leaves this cycle.
    assign busy = rsp_valid_reg && !rsp.ready;

    always_comb
    begin
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_item_reg <= result;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.item  = rsp_item_reg;

endmodule

[src/cpu_time_limit_quota_throttle_unit.sv]
// ----------------------------------------------------------------------------
// CPU time limit and quota throttle unit
// Hard and soft CPU-time limits with a per-period bandwidth quota.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register and moves on to the result
// register, from which rsp presents it, whenever the result stage is free.
// Throughput: one item per cycle while rsp is ready; the period compare and
// usage add lie between the input register and the result register.
// Reset clears the configuration registers, all accounting state and both
// valid flags at once; no clearing pass is needed.
module cpu_time_limit_quota_throttle_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cpu_tlq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpu_tlq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    cpu_tlq_req_if.sink                         req,
    cpu_tlq_rsp_if.source                       rsp
);
    import cpu_tlq_pkg::*;

    cfg_t      cfg;
    logic      req_valid_reg;
    logic      req_valid_next;
    in_item_t  req_item_reg;
    out_item_t result;
    logic      rsp_busy;
    logic      advance;

    // Configuration registers.
    cpu_tlq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The item in the input register moves on whenever the result stage is free.
    assign advance   = req_valid_reg && !rsp_busy;
    assign req.ready = !req_valid_reg || advance;

    always_comb
    begin
        if (req.valid && req.ready)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
        else
        begin
            req_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_item_reg <= req.item;
        end
    end

    // Accounting state and result logic.
    cpu_tlq_acct u_acct (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (req_item_reg),
        .result (result)
    );

    // Result register.
    cpu_tlq_cfg_dummy_guard u_rsp (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .busy   (rsp_busy),
        .rsp    (rsp)
    );

endmodule

[tb/cpu_tlq_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CPU time limit and quota throttle scoreboard
// Keeps a private copy of the limits, the accounting state and the period
// window. It works out the verdict that each accepted item must produce and
// checks every returned result against the oldest verdict still awaited.
// ----------------------------------------------------------------------------
package cpu_tlq_tb_pkg;
    import cpu_tlq_pkg::*;

    class quota_verdict_board;
        cfg_t               regs;
        logic [LIMIT_W-1:0] spent_ms;
        logic [USED_W-1:0]  window_used_us;
        logic [TICKS_W-1:0] window_start;
        logic               throttled;
        logic               soft_sent;
        out_item_t          awaited[$];
        int                 failures;

        function new();
            regs           = '0;
            spent_ms       = '0;
            window_used_us = '0;
            window_start   = '0;
            throttled      = 1'b0;
            soft_sent      = 1'b0;
            failures       = 0;
        endfunction

        // Register writes are plain stores, masked to the register width.
        function void write_register(input logic [CFG_IDX_W-1:0]  idx,
                                     input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HARD_ENABLE:   regs.hard_enable   = data[0];
                REG_HARD_LIMIT_MS: regs.hard_limit_ms = data[LIMIT_W-1:0];
                REG_SOFT_ENABLE:   regs.soft_enable   = data[0];
                REG_SOFT_LIMIT_MS: regs.soft_limit_ms = data[LIMIT_W-1:0];
                REG_QUOTA_US:      regs.quota_budget  = data[LIMIT_W-1:0];
                REG_PERIOD_US:     regs.period_len    = data[LIMIT_W-1:0];
                default:           ;
            endcase
        endfunction

        // Period check shared by ticks and queries; returns 1 when throttled.
        function logic window_check(input logic [TICKS_W-1:0] now);
            logic [TICKS_W-1:0] since;
            logic [TICKS_W-1:0] span;
            if (regs.quota_budget == '0)
                return 1'b0;
            since = now - window_start;
            span  = regs.period_len;
            span  = span / US_PER_TICK;
            if (since >= span)
            begin
                window_used_us = '0;
                window_start   = now;
                throttled      = 1'b0;
                return 1'b0;
            end
            if (window_used_us >= regs.quota_budget)
            begin
                throttled = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function out_item_t predict_verdict(input in_item_t it);
            out_item_t   v;
            logic [63:0] total;
            logic [63:0] used;
            v = '0;
            if (it.operation == OP_TICK)
            begin
                total = spent_ms + it.elapsed_ms;
                if (regs.hard_enable && total > regs.hard_limit_ms)
                begin
                    // Terminated: nothing is accounted and no quota check runs.
                    v.hard_exceeded = 1'b1;
                end
                else
                begin
                    if (regs.soft_enable && total > regs.soft_limit_ms && !soft_sent)
                    begin
                        soft_sent     = 1'b1;
                        v.soft_signal = 1'b1;
                    end
                    spent_ms = (total > {LIMIT_W{1'b1}}) ? {LIMIT_W{1'b1}}
                                                         : total[LIMIT_W-1:0];
                    if (regs.quota_budget != '0)
                    begin
                        used = window_used_us + it.elapsed_ms * US_PER_MS;
                        window_used_us = (used > {USED_W{1'b1}}) ? {USED_W{1'b1}}
                                                                 : used[USED_W-1:0];
                    end
                    v.quota_exceeded = window_check(it.now_ticks);
                end
            end
            else
            begin
                v.quota_exceeded = window_check(it.now_ticks);
                // A used-up CPU total blocks running even when the quota allows it.
                v.can_schedule = !v.quota_exceeded &&
                                 !(regs.hard_enable && spent_ms >= regs.hard_limit_ms);
            end
            return v;
        endfunction

        function void note_request(input in_item_t it);
            awaited.push_back(predict_verdict(it));
        endfunction

        function void compare_flag(input string name, input logic want, input logic got);
            if (got !== want)
            begin
                $display("%0t: %s expected %b, actual %b", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_verdict(input out_item_t got);
            out_item_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with no item awaiting it, expected none, actual %b",
                         $time, got);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_flag("hard_exceeded", want.hard_exceeded, got.hard_exceeded);
            compare_flag("soft_signal", want.soft_signal, got.soft_signal);
            compare_flag("quota_exceeded", want.quota_exceeded, got.quota_exceeded);
            compare_flag("can_schedule", want.can_schedule, got.can_schedule);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

endpackage

[tb/cpu_time_limit_quota_throttle_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CPU time limit and quota throttle unit testbench
// Drives ticks and schedule queries through a run of register settings,
// from a short directed sequence covering the limit, soft signal, period
// restart and timer wrap cases to random items with random sender gaps and
// receiver stalls. Every result is checked against the scoreboard.
// ----------------------------------------------------------------------------
module cpu_time_limit_quota_throttle_unit_tb;
    import cpu_tlq_pkg::*;
    import cpu_tlq_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 120;

    // Indexes beyond the register list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    cpu_tlq_req_if req_ch ();
    cpu_tlq_rsp_if rsp_ch ();

    quota_verdict_board board;
    logic [TICKS_W-1:0] tick_clock;
    bit                 req_steady;
    bit                 rsp_steady;
    int unsigned        cycle_count = 0;

    cpu_time_limit_quota_throttle_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #2 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int draw_wait(input bit steady);
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [LIMIT_W-1:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic cfg_t setting_of(input logic               he,
                                        input logic [LIMIT_W-1:0] hl,
                                        input logic               se,
                                        input logic [LIMIT_W-1:0] sl,
                                        input logic [LIMIT_W-1:0] q,
                                        input logic [LIMIT_W-1:0] p);
        cfg_t c;
        c.hard_enable   = he;
        c.hard_limit_ms = hl;
        c.soft_enable   = se;
        c.soft_limit_ms = sl;
        c.quota_budget  = q;
        c.period_len    = p;
        return c;
    endfunction

    // Half the limits sit a little above the running total so they get hit.
    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {LIMIT_W{1'b1}};
            2:       return rand40();
            default: return board.spent_ms + $urandom_range(0, 600000);
        endcase
    endfunction

    function automatic cfg_t pick_setting(input int phase);
        logic [LIMIT_W-1:0] quota;
        logic [LIMIT_W-1:0] period;
        if (phase == 0)
            return setting_of(1'b1, {LIMIT_W{1'b1}}, 1'b1, {LIMIT_W{1'b1}},
                              {LIMIT_W{1'b1}}, {LIMIT_W{1'b1}});
        if (phase == 1)
            return setting_of(1'b1, '0, 1'b1, '0, 40'd1, '0);
        case ($urandom_range(0, 6))
            0:       quota = '0;
            1:       quota = {LIMIT_W{1'b1}};
            2:       quota = rand40();
            default: quota = $urandom_range(1, 300000);
        endcase
        case ($urandom_range(0, 7))
            0:       period = '0;
            1:       period = $urandom_range(1, 999);
            2:       period = {LIMIT_W{1'b1}};
            3:       period = rand40();
            default: period = $urandom_range(1000, 40000);
        endcase
        return setting_of(1'($urandom), pick_limit(), 1'($urandom), pick_limit(),
                          quota, period);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        board.write_register(idx, data);
        @(posedge clk);
    endtask

    // Writes every register and one unmapped index; enable writes carry random upper bits.
    task automatic program_registers(input cfg_t c);
        logic [CFG_DATA_W-1:0] data;
        data = rand40();
        data[0] = c.hard_enable;
        write_register(REG_HARD_ENABLE, data);
        write_register(REG_HARD_LIMIT_MS, c.hard_limit_ms);
        data = rand40();
        data[0] = c.soft_enable;
        write_register(REG_SOFT_ENABLE, data);
        write_register(REG_SOFT_LIMIT_MS, c.soft_limit_ms);
        write_register(REG_QUOTA_US, c.quota_budget);
        write_register(REG_PERIOD_US, c.period_len);
        write_register($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, rand40());
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_item(input logic               op,
                             input logic [MS_W-1:0]    ms,
                             input logic [TICKS_W-1:0] now);
        int       gap;
        in_item_t it;
        gap = draw_wait(req_steady);
        it.operation  = op;
        it.elapsed_ms = ms;
        it.now_ticks  = now;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.item  <= it;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_request(it);
    endtask

    // Random traffic: mostly small elapsed times and a slowly moving timer,
    // with occasional full-range values, timer jumps and wraps.
    task automatic send_random_item();
        logic            op;
        logic [MS_W-1:0] ms;
        op = ($urandom_range(0, 9) < 3) ? OP_QUERY : OP_TICK;
        case ($urandom_range(0, 19))
            0, 1:    ms = 16'($urandom);
            2:       ms = {MS_W{1'b1}};
            3:       ms = '0;
            default: ms = 16'($urandom_range(0, 50));
        endcase
        case ($urandom_range(0, 39))
            0:       tick_clock = {$urandom, $urandom};
            1:       tick_clock = {TICKS_W{1'b1}} - $urandom_range(0, 20);
            default: tick_clock = tick_clock + $urandom_range(0, 3);
        endcase
        send_item(op, ms, tick_clock);
    endtask

    // Waits until every awaited result has arrived and the pipe is empty.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Result side: random stall before each item, then checks it.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(rsp_steady);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (rsp_ch.valid !== 1'b1)
                @(posedge clk);
            board.check_verdict(rsp_ch.item);
        end
    end

    initial
    begin
        logic [TICKS_W-1:0] mark;
        board = new();
        tick_clock = '0;
        req_steady = 1'b0;
        rsp_steady = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.item  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no limits and no quota.
        send_item(OP_QUERY, '0, '0);
        send_item(OP_TICK, '0, '0);
        settle();

        // Quota of 5 ms over a 10-tick period, soft and hard limits close by.
        program_registers(setting_of(1'b1, 40'd1000, 1'b1, 40'd500, 40'd5000, 40'd10000));
        send_item(OP_QUERY, '0, 64'd0);
        send_item(OP_TICK, 16'd0, 64'd1);
        send_item(OP_TICK, 16'd3, 64'd2);
        send_item(OP_TICK, 16'd3, 64'd3);
        send_item(OP_QUERY, '0, 64'd4);
        send_item(OP_QUERY, '0, 64'd12);
        send_item(OP_TICK, 16'd600, 64'd13);
        send_item(OP_TICK, 16'd395, 64'd14);
        send_item(OP_TICK, 16'd394, 64'd15);
        send_item(OP_QUERY, '0, 64'd30);
        send_item(OP_TICK, 16'd1, 64'd31);
        send_item(OP_TICK, 16'd0, 64'd32);
        send_item(OP_QUERY, '0, {TICKS_W{1'b1}});
        send_item(OP_TICK, 16'd0, 64'd2);
        settle();

        // Limits off, full quota and a period shorter than one tick.
        program_registers(setting_of(1'b0, {LIMIT_W{1'b1}}, 1'b0, {LIMIT_W{1'b1}},
                                     {LIMIT_W{1'b1}}, 40'd999));
        mark = 64'h5555_5555_AAAA_AAAA;
        send_item(OP_TICK, {MS_W{1'b1}}, {TICKS_W{1'b1}});
        send_item(OP_QUERY, '0, 64'hAAAA_AAAA_5555_5555);
        send_item(OP_TICK, {MS_W{1'b1}}, mark);
        settle();

        // Quota disabled, longest period, largest hard limit.
        program_registers(setting_of(1'b1, {LIMIT_W{1'b1}}, 1'b1, {LIMIT_W{1'b1}},
                                     '0, {LIMIT_W{1'b1}}));
        send_item(OP_TICK, 16'h8000, 64'd0);
        send_item(OP_QUERY, '0, 64'd7);
        settle();

        // Smallest quota in the longest period, then the period boundary.
        program_registers(setting_of(1'b0, '0, 1'b0, '0, 40'd1, {LIMIT_W{1'b1}}));
        send_item(OP_TICK, 16'd1, mark + 64'd1);
        send_item(OP_QUERY, '0, mark + 64'd2);
        send_item(OP_QUERY, '0, mark + 64'd1099511627);
        settle();

        // Random phases, each under its own settings and idling pattern.
        tick_clock = mark;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            program_registers(pick_setting(phase));
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_item();
            settle();
        end

        repeat (8) @(posedge clk);
        if (board.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
